FILE: rtl/occg_pkg.sv
package occg_pkg;

    // Default grid capacity.
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 256;

    // Field and datapath widths.
    localparam int CNT_W   = 8;
    localparam int REG_W   = 9;
    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int RAD_W   = 8;
    localparam int IDX_W   = 16;
    localparam int CHG_W   = 32;
    localparam int LIN_W   = 18;
    localparam int OFS_W   = 11;

    // Configuration register indexes.
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam logic [REG_W-1:0] GRID_RESET = 9'd256;

    typedef enum logic [1:0] {
        KIND_BLOCK,
        KIND_UNBLOCK,
        KIND_QUERY,
        KIND_SEARCH
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/occg_if.sv
// Request channel: one operation per beat.
interface occg_in_if;
    import occg_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
    logic [RAD_W-1:0]   ring_limit;

    modport source (output valid, kind, cell_x, cell_y, rect_width, rect_height, ring_limit,
                    input ready);
    modport sink   (input valid, kind, cell_x, cell_y, rect_width, rect_height, ring_limit,
                    output ready);
endinterface

// Response channel: one result per beat.
interface occg_out_if;
    import occg_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic             rect_is_free;
    logic             found;
    logic [IDX_W-1:0] cell_index;
    logic [CHG_W-1:0] change_count;

    modport source (output valid, status, rect_is_free, found, cell_index, change_count,
                    input ready);
    modport sink   (input valid, status, rect_is_free, found, cell_index, change_count,
                    output ready);
endinterface

FILE: rtl/occg_ram.sv
module occg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/occupancy_grid_rect_and_nearest_free_core.sv
// Occupancy grid with rectangle block, unblock, free query and nearest free cell search.
// Requests arrive on i_req (valid/ready); one result beat leaves on o_rsp per request.
// Grid width and height are set on the configuration port (index 0 and 1); the user must
// write them only while the block is idle, which the block itself does not enforce. A cell
// (x, y) is stored at y * width + x. The counts live in one single-port-read memory.
// Each visited cell passes three steps: address multiply, memory read, then check or
// read-modify-write. A query stops at the first nonzero cell and a search at the first
// free cell; ring positions outside the grid are skipped without a memory read, and a
// rectangle outside the grid or an empty one visits no cell. The result of a request
// appears in the same cycle that the next request can be taken.
// One request is worked on at a time; the result register lets the next request be taken
// while the previous result still waits for the receiver. If the receiver stalls, the
// finished item waits in its last state until the result register frees.
// After reset a clearing pass writes zero to every one of the MAX_COLUMNS * MAX_ROWS entries
// (65536 by default); no request is accepted until it ends. Configuration writes are taken
// at any time, and the grid size resets to 256 by 256.
module occupancy_grid_rect_and_nearest_free_core #(
    parameter int MAX_COLUMNS = occg_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = occg_pkg::DEF_MAX_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [occg_pkg::REG_W-1:0] i_cfg_data,
    occg_in_if.sink                    i_req,
    occg_out_if.source                 o_rsp
);
    import occg_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [REG_W-1:0]   r_gw, r_gh;
    logic [AW-1:0]      r_clr, n_clr;
    t_kind              r_kind, n_kind;
    logic [COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [SIZE_W-1:0]  r_w, n_w, r_h, n_h;
    logic [RAD_W-1:0]   r_maxr, n_maxr, r_rad, n_rad;
    logic signed [OFS_W-1:0] r_dx, n_dx, r_dy, n_dy;
    logic [LIN_W-1:0]   r_lin, n_lin;
    logic [CHG_W-1:0]   r_chg, n_chg;
    logic               r_status, n_status, r_free, n_free, r_found, n_found;

    logic               r_ovalid, n_ovalid;
    logic               r_o_status, n_o_status, r_o_free, n_o_free, r_o_found, n_o_found;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;
    logic [CHG_W-1:0]   r_o_chg, n_o_chg;

    logic [REG_W-1:0]   w_effc, w_effr;
    logic signed [OFS_W-1:0] w_px, w_py, w_rad, w_step, w_dx_inc;
    logic               w_ingrid, w_edge;
    logic [LIN_W-1:0]   w_prod;
    logic               w_adv_done;
    logic signed [OFS_W-1:0] w_adv_dx, w_adv_dy;
    logic [RAD_W-1:0]   w_adv_rad;
    logic [SIZE_W:0]    w_xend, w_yend;
    logic               w_inside, w_slot_free;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [CNT_W-1:0]   w_wdata, w_rdata;

    // Effective grid size.
    assign w_effc = (13'(r_gw) > 13'(MAX_COLUMNS)) ? REG_W'(MAX_COLUMNS) : r_gw;
    assign w_effr = (13'(r_gh) > 13'(MAX_ROWS))    ? REG_W'(MAX_ROWS)    : r_gh;

    // Current cell position and its linear address.
    assign w_px     = $signed(OFS_W'(r_cx)) + r_dx;
    assign w_py     = $signed(OFS_W'(r_cy)) + r_dy;
    assign w_ingrid = !w_px[OFS_W-1] && !w_py[OFS_W-1]
                      && (w_px < $signed(OFS_W'(w_effc)))
                      && (w_py < $signed(OFS_W'(w_effr)));
    assign w_prod   = LIN_W'(w_py[REG_W-1:0]) * LIN_W'(w_effc) + LIN_W'(w_px[REG_W-1:0]);

    // Rectangle bounds check on the incoming request.
    assign w_xend   = (SIZE_W+1)'(i_req.cell_x) + (SIZE_W+1)'(i_req.rect_width);
    assign w_yend   = (SIZE_W+1)'(i_req.cell_y) + (SIZE_W+1)'(i_req.rect_height);
    assign w_inside = (w_xend <= (SIZE_W+1)'(w_effc)) && (w_yend <= (SIZE_W+1)'(w_effr));

    // Next position: row-major over the rectangle, or ring order for a search.
    assign w_rad    = $signed(OFS_W'(r_rad));
    assign w_edge   = (r_dy == -w_rad) || (r_dy == w_rad);
    assign w_step   = w_edge ? OFS_W'(1) : (w_rad <<< 1);
    assign w_dx_inc = r_dx + w_step;

    always_comb begin
        w_adv_done = 1'b0;
        w_adv_dx   = r_dx;
        w_adv_dy   = r_dy;
        w_adv_rad  = r_rad;
        if (r_kind == KIND_SEARCH) begin
            if (w_dx_inc > w_rad) begin
                if (r_dy + OFS_W'(1) > w_rad) begin
                    if (r_rad == r_maxr) begin
                        w_adv_done = 1'b1;
                    end else begin
                        w_adv_rad = r_rad + RAD_W'(1);
                        w_adv_dx  = -(w_rad + OFS_W'(1));
                        w_adv_dy  = -(w_rad + OFS_W'(1));
                    end
                end else begin
                    w_adv_dy = r_dy + OFS_W'(1);
                    w_adv_dx = -w_rad;
                end
            end else begin
                w_adv_dx = w_dx_inc;
            end
        end else begin
            if (r_dx + OFS_W'(1) == $signed(OFS_W'(r_w))) begin
                if (r_dy + OFS_W'(1) == $signed(OFS_W'(r_h))) begin
                    w_adv_done = 1'b1;
                end else begin
                    w_adv_dy = r_dy + OFS_W'(1);
                    w_adv_dx = '0;
                end
            end else begin
                w_adv_dx = r_dx + OFS_W'(1);
            end
        end
    end

    assign w_slot_free = !r_ovalid || o_rsp.ready;

    // Sequencer: next state, memory writes and result loading.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_kind     = r_kind;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_w        = r_w;
        n_h        = r_h;
        n_maxr     = r_maxr;
        n_rad      = r_rad;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_lin      = r_lin;
        n_chg      = r_chg;
        n_status   = r_status;
        n_free     = r_free;
        n_found    = r_found;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_free   = r_o_free;
        n_o_found  = r_o_found;
        n_o_idx    = r_o_idx;
        n_o_chg    = r_o_chg;
        w_we       = 1'b0;
        w_waddr    = AW'(r_lin);
        w_wdata    = '0;
        i_req.ready = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_kind   = t_kind'(i_req.kind);
                    n_cx     = i_req.cell_x;
                    n_cy     = i_req.cell_y;
                    n_w      = i_req.rect_width;
                    n_h      = i_req.rect_height;
                    n_maxr   = i_req.ring_limit;
                    n_rad    = '0;
                    n_dx     = '0;
                    n_dy     = '0;
                    n_status = 1'b0;
                    n_found  = 1'b0;
                    n_free   = 1'b0;
                    if (t_kind'(i_req.kind) == KIND_SEARCH) begin
                        n_state = ST_CALC;
                    end else if (!w_inside) begin
                        n_status = 1'b1;
                        n_state  = ST_FINISH;
                    end else if (i_req.rect_width == '0 || i_req.rect_height == '0) begin
                        n_free  = (t_kind'(i_req.kind) == KIND_QUERY);
                        if (t_kind'(i_req.kind) != KIND_QUERY) begin
                            n_chg = r_chg + CHG_W'(1);
                        end
                        n_state = ST_FINISH;
                    end else begin
                        n_free  = (t_kind'(i_req.kind) == KIND_QUERY);
                        n_state = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                n_lin = w_prod;
                if (w_ingrid) begin
                    n_state = ST_READ;
                end else begin
                    // Ring positions off the grid are skipped without a memory access.
                    n_dx  = w_adv_dx;
                    n_dy  = w_adv_dy;
                    n_rad = w_adv_rad;
                    if (w_adv_done) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_dx    = w_adv_dx;
                n_dy    = w_adv_dy;
                n_rad   = w_adv_rad;
                n_state = w_adv_done ? ST_FINISH : ST_CALC;
                unique case (r_kind)
                    KIND_BLOCK, KIND_UNBLOCK: begin
                        w_we    = 1'b1;
                        w_wdata = (r_kind == KIND_BLOCK) ? w_rdata + CNT_W'(1)
                                                         : w_rdata - CNT_W'(1);
                        if (w_adv_done) begin
                            n_chg = r_chg + CHG_W'(1);
                        end
                    end
                    KIND_QUERY: begin
                        if (w_rdata != '0) begin
                            n_free  = 1'b0;
                            n_state = ST_FINISH;
                        end
                    end
                    KIND_SEARCH: begin
                        if (w_rdata == '0) begin
                            n_found = 1'b1;
                            n_state = ST_FINISH;
                        end
                    end
                    default: ;
                endcase
            end
            ST_FINISH: begin
                if (w_slot_free) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_free   = r_free;
                    n_o_found  = r_found;
                    n_o_idx    = r_found ? r_lin[IDX_W-1:0] : '0;
                    n_o_chg    = r_chg;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_chg    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_chg    <= n_chg;
            r_ovalid <= n_ovalid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GRID_RESET;
            r_gh <= GRID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_gw <= i_cfg_data;
                CFG_GRID_HEIGHT: r_gh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Operation and result payload.
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_w        <= n_w;
        r_h        <= n_h;
        r_maxr     <= n_maxr;
        r_rad      <= n_rad;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_lin      <= n_lin;
        r_status   <= n_status;
        r_free     <= n_free;
        r_found    <= n_found;
        r_o_status <= n_o_status;
        r_o_free   <= n_o_free;
        r_o_found  <= n_o_found;
        r_o_idx    <= n_o_idx;
        r_o_chg    <= n_o_chg;
    end

    occg_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (AW'(r_lin)),
        .o_rdata (w_rdata)
    );

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.rect_is_free = r_o_free;
    assign o_rsp.found        = r_o_found;
    assign o_rsp.cell_index   = r_o_idx;
    assign o_rsp.change_count = r_o_chg;
endmodule

FILE: rtl/occg_chk.sv
module occg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_status,
    input logic        i_free,
    input logic        i_found,
    input logic [15:0] i_idx,
    input logic [31:0] i_chg
);
    logic        r_seen;
    logic [31:0] r_last_chg;

    // Remember the change count of the last delivered beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_valid && i_ready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_ready) begin
            r_last_chg <= i_chg;
        end
    end

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // An ignored rectangle reports neither a free rectangle nor a found cell.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status |-> !i_free && !i_found)
        else $error("ignored rectangle with result flags set");

    // No cell index without a found cell.
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_found |-> i_idx == 16'd0)
        else $error("cell index set without a found cell");

    // Each operation bumps the change count by at most one.
    a_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_seen |-> (i_chg == r_last_chg) || (i_chg == r_last_chg + 32'd1))
        else $error("change count jumped");
endmodule

bind occupancy_grid_rect_and_nearest_free_core occg_chk u_occg_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.status),
    .i_free   (o_rsp.rect_is_free),
    .i_found  (o_rsp.found),
    .i_idx    (o_rsp.cell_index),
    .i_chg    (o_rsp.change_count)
);
